/* rtl/dtp_pkg.sv */
`timescale 1ns / 1ps

package dtp_pkg;

    localparam int DIGIT_LIMIT = 19;
    localparam int RUN_W = $clog2(DIGIT_LIMIT + 1);

    localparam int FULL_DATE_LEN = 8;
    localparam int YEAR_MONTH_LEN = 6;
    localparam int YEAR_LEN = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    localparam int PADDR_W = 3;

    typedef enum logic [0:0] {
        CFG_US_STYLE  = 1'b0,
        CFG_FIELD_SEP = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] character;
        logic       field_last;
    } t_in_item;

    typedef struct packed {
        logic        parsed_ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
    } t_out_item;

    typedef struct packed {
        logic [7:0] character;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_sep;
        logic       field_last;
    } t_cls_item;

endpackage

/* rtl/dtp_front.sv */
`timescale 1ns / 1ps

module dtp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dtp_pkg::t_in_item   i_in_data,
    input  logic [7:0]          i_field_sep,
    input  logic                i_queue_full,
    output logic                o_push,
    output dtp_pkg::t_cls_item  o_push_data
);

    logic               r_valid;
    dtp_pkg::t_cls_item r_item;
    dtp_pkg::t_cls_item n_item;
    logic               accept;
    logic [7:0]         offset;

    assign o_in_stall  = r_valid && i_queue_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_push      = r_valid && !i_queue_full;
    assign o_push_data = r_item;

    always_comb begin
        offset              = i_in_data.character - dtp_pkg::CHAR_ZERO;
        n_item.character    = i_in_data.character;
        n_item.digit        = offset[3:0];
        n_item.is_digit     = (i_in_data.character >= dtp_pkg::CHAR_ZERO)
                              && (i_in_data.character <= dtp_pkg::CHAR_NINE);
        n_item.is_sep       = (i_in_data.character == i_field_sep);
        n_item.field_last   = i_in_data.field_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/dtp_queue.sv */
`timescale 1ns / 1ps

module dtp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dtp_pkg::t_cls_item  i_push_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output dtp_pkg::t_cls_item  o_data
);

    dtp_pkg::t_cls_item               r_mem [dtp_pkg::QUEUE_DEPTH];
    logic [dtp_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [dtp_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [dtp_pkg::QUEUE_CW-1:0]     r_count;

    assign o_full  = (r_count == dtp_pkg::QUEUE_CW'(dtp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/dtp_back.sv */
`timescale 1ns / 1ps

module dtp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  dtp_pkg::t_cls_item  i_data,
    output logic                o_pop,
    input  logic                i_us_style,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dtp_pkg::t_out_item  o_out_data
);

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_MONTH,
        PH_DAY,
        PH_US_DAY,
        PH_US_YEAR
    } t_phase;

    typedef enum logic [1:0] {
        V_UNDECIDED,
        V_OK,
        V_FAIL
    } t_verdict;

    typedef struct packed {
        t_phase                      phase;
        logic [dtp_pkg::RUN_W-1:0]   run;
        logic [13:0]                 year;
        logic [6:0]                  month;
        logic [6:0]                  day;
        logic [7:0]                  delim;
        t_verdict                    verdict;
    } t_parse;

    localparam t_parse CLEAR_STATE = '{
        phase: PH_FIRST, run: '0, year: '0, month: '0, day: '0,
        delim: '0, verdict: V_UNDECIDED};

    function automatic logic [13:0] mul10_add14(input logic [13:0] x, input logic [3:0] d);
        logic [16:0] t;
        t = {x, 3'b000} + {2'b00, x, 1'b0} + {13'b0, d};
        return t[13:0];
    endfunction

    function automatic logic [6:0] mul10_add7(input logic [6:0] x, input logic [3:0] d);
        logic [9:0] t;
        t = {x, 3'b000} + {2'b00, x, 1'b0} + {6'b0, d};
        return t[6:0];
    endfunction

    function automatic t_parse take_digit(input t_parse s, input logic [3:0] d);
        t_parse r;
        r = s;
        case (s.phase)
            PH_FIRST: begin
                if (s.run < dtp_pkg::RUN_W'(dtp_pkg::YEAR_LEN)) begin
                    r.year = mul10_add14(s.year, d);
                end else if (s.run < dtp_pkg::RUN_W'(dtp_pkg::YEAR_MONTH_LEN)) begin
                    r.month = mul10_add7(s.month, d);
                end else if (s.run < dtp_pkg::RUN_W'(dtp_pkg::FULL_DATE_LEN)) begin
                    r.day = mul10_add7(s.day, d);
                end
            end
            PH_MONTH: begin
                if (s.run < dtp_pkg::RUN_W'(2)) begin
                    r.month = mul10_add7(s.month, d);
                end
            end
            PH_DAY, PH_US_DAY: begin
                if (s.run < dtp_pkg::RUN_W'(2)) begin
                    r.day = mul10_add7(s.day, d);
                end
            end
            default: begin
                if (s.run < dtp_pkg::RUN_W'(dtp_pkg::YEAR_LEN)) begin
                    r.year = mul10_add14(s.year, d);
                end
            end
        endcase
        r.run = s.run + 1'b1;
        return r;
    endfunction

    function automatic t_parse take_term(input t_parse s, input logic [7:0] c,
                                         input logic is_sep, input logic at_end,
                                         input logic us);
        t_parse r;
        logic   short_run;
        r = s;
        short_run = (s.run == dtp_pkg::RUN_W'(1)) || (s.run == dtp_pkg::RUN_W'(2));
        case (s.phase)
            PH_FIRST: begin
                if ((s.run == dtp_pkg::RUN_W'(dtp_pkg::FULL_DATE_LEN))
                        || (s.run == dtp_pkg::RUN_W'(dtp_pkg::YEAR_MONTH_LEN))) begin
                    r.verdict = V_OK;
                end else if (s.run == dtp_pkg::RUN_W'(dtp_pkg::YEAR_LEN)) begin
                    if (at_end) begin
                        r.verdict = V_FAIL;
                    end else begin
                        r.delim = c;
                        r.phase = PH_MONTH;
                        r.run   = '0;
                    end
                end else if (us && short_run) begin
                    r.month = s.year[6:0];
                    r.year  = '0;
                    if (at_end || is_sep) begin
                        r.verdict = V_FAIL;
                    end else begin
                        r.delim = c;
                        r.phase = PH_US_DAY;
                        r.run   = '0;
                    end
                end else begin
                    r.verdict = V_FAIL;
                end
            end
            PH_MONTH: begin
                if (!short_run) begin
                    r.verdict = V_FAIL;
                end else if (!at_end && (c == s.delim)) begin
                    r.phase = PH_DAY;
                    r.run   = '0;
                end else begin
                    r.verdict = V_OK;
                end
            end
            PH_DAY: begin
                r.verdict = short_run ? V_OK : V_FAIL;
            end
            PH_US_DAY: begin
                if (short_run && !at_end && (c == s.delim)) begin
                    r.phase = PH_US_YEAR;
                    r.run   = '0;
                end else begin
                    r.verdict = V_FAIL;
                end
            end
            default: begin
                r.verdict = (s.run == dtp_pkg::RUN_W'(dtp_pkg::YEAR_LEN)) ? V_OK : V_FAIL;
            end
        endcase
        return r;
    endfunction

    t_parse             r_state;
    t_parse             s_byte;
    t_parse             s_end;
    logic               r_out_valid;
    dtp_pkg::t_out_item r_out_data;
    dtp_pkg::t_out_item n_out_data;

    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        s_byte = r_state;
        if (r_state.verdict == V_UNDECIDED) begin
            if (i_data.is_digit && (r_state.run < dtp_pkg::RUN_W'(dtp_pkg::DIGIT_LIMIT))) begin
                s_byte = take_digit(r_state, i_data.digit);
            end else begin
                s_byte = take_term(r_state, i_data.character, i_data.is_sep, 1'b0,
                                   i_us_style);
            end
        end
        s_end = s_byte;
        if (s_byte.verdict == V_UNDECIDED) begin
            s_end = take_term(s_byte, 8'd0, 1'b0, 1'b1, i_us_style);
        end
        if (s_end.verdict == V_OK) begin
            n_out_data.parsed_ok = 1'b1;
            n_out_data.year      = s_end.year;
            n_out_data.month     = s_end.month;
            n_out_data.day       = (s_end.day == '0) ? 7'd1 : s_end.day;
        end else begin
            n_out_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CLEAR_STATE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state <= i_data.field_last ? CLEAR_STATE : s_byte;
            end
            if (o_pop && i_data.field_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_data.field_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

/* rtl/date_text_parser_core.sv */
`timescale 1ns / 1ps
// A byte with field_last passes the front register and the queue; its result is
// registered in the result register. Throughput: one byte per cycle unless stalled;
// a stalled output backs up through a 4-entry queue.
// Reset: synchronous active-low; us_style clears, field_separator returns to 44,
// the parse restarts at the start of a field and the queue empties.

module date_text_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dtp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dtp_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtp_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic               r_us_style;
    logic [7:0]         r_field_sep;
    logic               cfg_write;
    dtp_pkg::t_cfg_idx  cfg_idx;
    logic               queue_full;
    logic               push;
    dtp_pkg::t_cls_item push_data;
    logic               pop;
    logic               queue_valid;
    dtp_pkg::t_cls_item queue_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = dtp_pkg::t_cfg_idx'(paddr[2]);

    always_comb begin
        case (cfg_idx)
            dtp_pkg::CFG_US_STYLE:  prdata = {31'b0, r_us_style};
            dtp_pkg::CFG_FIELD_SEP: prdata = {24'b0, r_field_sep};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_us_style  <= 1'b0;
            r_field_sep <= dtp_pkg::SEP_RESET;
        end else if (cfg_write) begin
            case (cfg_idx)
                dtp_pkg::CFG_US_STYLE:  r_us_style  <= pwdata[0];
                dtp_pkg::CFG_FIELD_SEP: r_field_sep <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    dtp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_field_sep  (r_field_sep),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    dtp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_valid     (queue_valid),
        .o_data      (queue_data)
    );

    dtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_data      (queue_data),
        .o_pop       (pop),
        .i_us_style  (r_us_style),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/dtp_date_checker.sv */
`timescale 1ns / 1ps

module dtp_date_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  dtp_pkg::t_in_item            i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  dtp_pkg::t_out_item           i_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dtp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count,
    output int                           o_good_count
);

    typedef enum logic [2:0] {
        ST_LEAD,
        ST_MONTH,
        ST_DAY,
        ST_US_DAY,
        ST_US_YEAR
    } t_stage;

    typedef enum logic [1:0] {
        VD_OPEN,
        VD_GOOD,
        VD_BAD
    } t_verdict;

    logic                      us_mode;
    logic [7:0]                sep_char;
    t_stage                    stage;
    logic [dtp_pkg::RUN_W-1:0] run_len;
    logic [13:0]               yr;
    logic [6:0]                mo;
    logic [6:0]                dy;
    logic [7:0]                delim;
    t_verdict                  vd;

    dtp_pkg::t_out_item expected_dates[$];
    int                 fails      = 0;
    int                 results    = 0;
    int                 good_dates = 0;
    int                 pending    = 0;

    assign o_fail_count   = fails;
    assign o_pending      = pending;
    assign o_result_count = results;
    assign o_good_count   = good_dates;

    function automatic void clear_parse();
        stage   = ST_LEAD;
        run_len = '0;
        yr      = '0;
        mo      = '0;
        dy      = '0;
        delim   = '0;
        vd      = VD_OPEN;
    endfunction

    function automatic void add_digit(input logic [3:0] d);
        case (stage)
            ST_LEAD: begin
                if (run_len < dtp_pkg::YEAR_LEN) yr = 14'(yr * 10 + d);
                else if (run_len < dtp_pkg::YEAR_MONTH_LEN) mo = 7'(mo * 10 + d);
                else if (run_len < dtp_pkg::FULL_DATE_LEN) dy = 7'(dy * 10 + d);
            end
            ST_MONTH: begin
                if (run_len < 2) mo = 7'(mo * 10 + d);
            end
            ST_DAY, ST_US_DAY: begin
                if (run_len < 2) dy = 7'(dy * 10 + d);
            end
            default: begin
                if (run_len < dtp_pkg::YEAR_LEN) yr = 14'(yr * 10 + d);
            end
        endcase
        run_len = run_len + 1'b1;
    endfunction

    // close the current digit run on a non-digit byte, a digit past DIGIT_LIMIT or the field end
    function automatic void end_run(input logic [7:0] c, input logic at_end);
        logic short_run;
        short_run = (run_len == 1 || run_len == 2);
        case (stage)
            ST_LEAD: begin
                if (run_len == dtp_pkg::FULL_DATE_LEN
                        || run_len == dtp_pkg::YEAR_MONTH_LEN) begin
                    vd = VD_GOOD;
                end else if (run_len == dtp_pkg::YEAR_LEN) begin
                    if (at_end) begin
                        vd = VD_BAD;
                    end else begin
                        delim   = c;
                        stage   = ST_MONTH;
                        run_len = '0;
                    end
                end else if (us_mode && short_run) begin
                    mo = yr[6:0];
                    yr = '0;
                    if (at_end || c == sep_char) begin
                        vd = VD_BAD;
                    end else begin
                        delim   = c;
                        stage   = ST_US_DAY;
                        run_len = '0;
                    end
                end else begin
                    vd = VD_BAD;
                end
            end
            ST_MONTH: begin
                if (!short_run) begin
                    vd = VD_BAD;
                end else if (!at_end && c == delim) begin
                    stage   = ST_DAY;
                    run_len = '0;
                end else begin
                    vd = VD_GOOD;
                end
            end
            ST_DAY: begin
                vd = short_run ? VD_GOOD : VD_BAD;
            end
            ST_US_DAY: begin
                if (short_run && !at_end && c == delim) begin
                    stage   = ST_US_YEAR;
                    run_len = '0;
                end else begin
                    vd = VD_BAD;
                end
            end
            default: begin
                vd = (run_len == dtp_pkg::YEAR_LEN) ? VD_GOOD : VD_BAD;
            end
        endcase
    endfunction

    function automatic void take_byte(input dtp_pkg::t_in_item it);
        dtp_pkg::t_out_item r;
        logic [7:0]         offs;
        offs = it.character - dtp_pkg::CHAR_ZERO;
        if (vd == VD_OPEN) begin
            if (it.character >= dtp_pkg::CHAR_ZERO && it.character <= dtp_pkg::CHAR_NINE
                    && run_len < dtp_pkg::DIGIT_LIMIT)
                add_digit(offs[3:0]);
            else
                end_run(it.character, 1'b0);
        end
        if (it.field_last) begin
            if (vd == VD_OPEN) end_run(8'd0, 1'b1);
            if (vd == VD_GOOD) begin
                r = '{parsed_ok: 1'b1, year: yr, month: mo,
                      day: (dy == 7'd0) ? 7'd1 : dy};
            end else begin
                r = '0;
            end
            expected_dates.push_back(r);
            clear_parse();
        end
    endfunction

    always @(posedge i_clk) begin
        dtp_pkg::t_out_item want;
        if (!i_rst_n) begin
            us_mode  = 1'b0;
            sep_char = dtp_pkg::SEP_RESET;
            clear_parse();
            expected_dates.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (dtp_pkg::t_cfg_idx'(paddr[dtp_pkg::PADDR_W-1:2]))
                    dtp_pkg::CFG_US_STYLE:  us_mode  = pwdata[0];
                    dtp_pkg::CFG_FIELD_SEP: sep_char = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) take_byte(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (expected_dates.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected date transaction, expected none, %s",
                             $time, "actual:");
                    $display("    ok=%0d y=%0d m=%0d d=%0d",
                             i_out_data.parsed_ok, i_out_data.year,
                             i_out_data.month, i_out_data.day);
                end else begin
                    want = expected_dates.pop_front();
                    if (want.parsed_ok) good_dates++;
                    if (i_out_data !== want) begin
                        fails++;
                        $display("%0t: date mismatch, expected ok=%0d y=%0d m=%0d d=%0d,",
                                 $time, want.parsed_ok, want.year, want.month,
                                 want.day);
                        $display("    actual ok=%0d y=%0d m=%0d d=%0d",
                                 i_out_data.parsed_ok, i_out_data.year,
                                 i_out_data.month, i_out_data.day);
                    end
                end
            end
        end
        pending = expected_dates.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int RESET_CYCLES   = 11;
    localparam int PHASES         = 6;
    localparam int BYTES_PER_PHASE = 235;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    dtp_pkg::t_in_item           in_data;
    logic                        out_valid;
    logic                        out_stall;
    dtp_pkg::t_out_item          out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dtp_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int result_count;
    int good_count;

    logic steady;
    logic hold_req;
    int   idle_cycles = 0;
    int   bytes_sent;
    int   fields_sent;

    logic [7:0] field_bytes[$];
    logic       us_plan[PHASES]  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [7:0] sep_plan[PHASES] = '{8'd44, 8'd44, 8'd0, 8'd255, 8'd255, 8'd59};

    always #4 clk = ~clk;

    date_text_parser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dtp_date_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_good_count   (good_count)
    );

    function automatic logic [7:0] any_digit();
        return dtp_pkg::CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] any_delim();
        int r;
        r = $urandom_range(245);
        if (r >= dtp_pkg::CHAR_ZERO) r = r + 10;
        return 8'(r);
    endfunction

    function automatic logic [7:0] pick_delim(input logic [7:0] sep);
        return ($urandom_range(99) < 15) ? sep : any_delim();
    endfunction

    function automatic int short_len();
        int r;
        r = $urandom_range(99);
        if (r < 88) return $urandom_range(1, 2);
        if (r < 94) return 0;
        return 3;
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) field_bytes.push_back(any_digit());
    endfunction

    function automatic void load_text(input string s);
        field_bytes.delete();
        for (int i = 0; i < s.len(); i++) field_bytes.push_back(s[i]);
    endfunction

    function automatic void build_field(input logic [7:0] sep);
        int         k;
        logic [7:0] d;
        field_bytes.delete();
        k = $urandom_range(99);
        if (k < 20) begin
            case ($urandom_range(5))
                0, 1:    push_digits(8);
                2, 3:    push_digits(6);
                default: push_digits($urandom_range(1, 9));
            endcase
        end else if (k < 50) begin
            push_digits(($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4);
            d = pick_delim(sep);
            field_bytes.push_back(d);
            push_digits(short_len());
            if ($urandom_range(99) < 65) begin
                field_bytes.push_back(($urandom_range(99) < 85) ? d : any_delim());
                push_digits(short_len());
            end
        end else if (k < 78) begin
            push_digits(short_len());
            d = pick_delim(sep);
            field_bytes.push_back(d);
            push_digits(short_len());
            field_bytes.push_back(($urandom_range(99) < 85) ? d : any_delim());
            push_digits(($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4);
        end else if (k < 88) begin
            push_digits($urandom_range(17, 24));
        end else begin
            repeat ($urandom_range(1, 6)) field_bytes.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 25)
            repeat ($urandom_range(1, 3)) field_bytes.push_back(8'($urandom_range(255)));
        if (field_bytes.size() == 0) field_bytes.push_back(8'($urandom_range(255)));
    endfunction

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic put_byte(input logic [7:0] ch, input logic last);
        while (!steady && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{character: ch, field_last: last};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_field();
        for (int i = 0; i < field_bytes.size(); i++)
            put_byte(field_bytes[i], i == field_bytes.size() - 1);
        bytes_sent  += field_bytes.size();
        fields_sent++;
    endtask

    task automatic write_reg(input dtp_pkg::t_cfg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dtp_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_setting(input logic us, input logic [7:0] sep);
        write_reg(dtp_pkg::CFG_US_STYLE, ($urandom() & ~32'h1) | {31'd0, us});
        write_reg(dtp_pkg::CFG_FIELD_SEP, ($urandom() & ~32'hFF) | {24'd0, sep});
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < 18);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no transaction for %0d cycles",
                         $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int phase_bytes;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        bytes_sent  = 0;
        fields_sent = 0;
        sep_plan[PHASES-1] = any_delim();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_setting(us_plan[0], sep_plan[0]);
        load_text("99991231");
        send_field();
        load_text("0000-0");
        send_field();
        field_bytes = '{8'hFF};
        send_field();
        load_text("2024");
        send_field();

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain();
                load_setting(us_plan[p], sep_plan[p]);
            end
            steady = (p == 2 || p == 3);
            if (p == 3) hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) begin
                build_field(sep_plan[p]);
                phase_bytes += field_bytes.size();
                send_field();
            end
        end
        steady = 1'b0;
        drain();

        $display("Ran %0d fields (%0d bytes) giving %0d results, %0d valid dates,",
                 fields_sent, bytes_sent, result_count, good_count);
        $display("across %0d register settings with a %0d-cycle output hold.",
                 PHASES, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
